// ===== rtl/core/tswbc_pkg.sv =====
// Shared widths, codes and reset values for the two-slot write-back block cache.
package tswbc_pkg;

  localparam int unsigned MaxBlockWordsDef = 32;
  localparam int unsigned AddressBitsDef   = 20;

  localparam int unsigned ActionW    = 2;
  localparam int unsigned IndexW     = 21;
  localparam int unsigned IdxW       = 20;
  localparam int unsigned ValueW     = 64;
  localparam int unsigned KindW      = 3;
  localparam int unsigned ArraySizeW = 21;
  localparam int unsigned BlockSizeW = 6;
  localparam int unsigned BlockNumW  = 20;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 21;

  localparam logic [ArraySizeW-1:0] ArraySizeRst = 21'h100000;
  localparam logic [BlockSizeW-1:0] BlockSizeRst = 6'd32;

  localparam logic [CfgIdxW-1:0] CfgArraySize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBlockSize = 1'b1;

  typedef enum logic [ActionW-1:0] {
    ActRead  = 2'd0,
    ActWrite = 2'd1,
    ActFill  = 2'd2,
    ActBad   = 2'd3
  } action_e;

  typedef enum logic [KindW-1:0] {
    KindRead  = 3'd0,
    KindWrite = 3'd1,
    KindWb    = 3'd2,
    KindFill  = 3'd3,
    KindRange = 3'd4,
    KindProto = 3'd5
  } kind_e;

endpackage

// ===== rtl/core/two_slot_writeback_block_cache_unit.sv =====
// Two-slot direct-mapped write-back block cache with fill and writeback sequencing.
//
// Two block slots sit in front of an external element store; block b = index / block_size
// lives in slot b mod 2. Requests enter on start while busy is low. Every result shows
// on the result ports for exactly one cycle, marked by result_valid_o; the receiver cannot
// stall it, so it must take each result in the cycle it appears. A protocol error or an
// out-of-range request answers in the cycle after the request and leaves busy low. A
// read or write request runs a bit-serial restoring divider (one quotient bit per cycle)
// to split the index into block number and offset, then a lookup: a hit reads the word
// store (registered read data) and then answers. A miss on a dirty slot first streams
// the old block out word by word (store read, then result), then issues the fill
// request and drops busy. Fill words are then taken one per cycle with no result; the
// last one completes the held access through a store read and a result stage. Fill words
// go straight into the word store. The word store (2 * MAX_BLOCK_WORDS x 64, one write
// and one read port) is not cleared after reset: a slot becomes readable only after its
// block has been filled. Register writes are ignored while a fill is awaited.
module two_slot_writeback_block_cache_unit #(
  parameter int unsigned MAX_BLOCK_WORDS = tswbc_pkg::MaxBlockWordsDef,
  parameter int unsigned ADDRESS_BITS    = tswbc_pkg::AddressBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [tswbc_pkg::ActionW-1:0]       action_i,
  input  logic signed [tswbc_pkg::IndexW-1:0] index_i,
  input  logic [tswbc_pkg::ValueW-1:0]        value_i,
  input  logic                                cfg_we_i,
  input  logic [tswbc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [tswbc_pkg::CfgDataW-1:0]      cfg_data_i,
  output logic                                result_valid_o,
  output logic [tswbc_pkg::KindW-1:0]         kind_o,
  output logic [ADDRESS_BITS-1:0]             address_o,
  output logic [tswbc_pkg::ValueW-1:0]        data_o,
  output logic                                last_o
);
  import tswbc_pkg::*;

  localparam int unsigned MemDepth = 2 * MAX_BLOCK_WORDS;
  localparam int unsigned MemAw    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int unsigned WideW    = (ADDRESS_BITS > 27) ? ADDRESS_BITS : 27;
  localparam int unsigned CntW     = $clog2(IdxW);
  localparam logic [BlockSizeW-1:0] MaxBs = BlockSizeW'(MAX_BLOCK_WORDS);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DIV      = 8'b0000_0010,
    S_LOOK     = 8'b0000_0100,
    S_WB_RD    = 8'b0000_1000,
    S_WB_OUT   = 8'b0001_0000,
    S_FILL_REQ = 8'b0010_0000,
    S_RD       = 8'b0100_0000,
    S_HIT_RD   = 8'b1000_0000
  } state_e;

  // Control state
  state_e                     state_q, state_d;
  logic [ArraySizeW-1:0]      array_size_q, array_size_d;
  logic [BlockSizeW-1:0]      block_size_q, block_size_d;
  logic [1:0]                 slot_valid_q, slot_valid_d;
  logic [1:0]                 slot_dirty_q, slot_dirty_d;
  logic [1:0][BlockNumW-1:0]  slot_bn_q, slot_bn_d;
  logic                       waiting_q, waiting_d;
  logic [BlockSizeW-1:0]      fill_cnt_q, fill_cnt_d;
  logic [CntW-1:0]            div_cnt_q, div_cnt_d;
  logic [BlockSizeW-1:0]      wb_k_q, wb_k_d;
  logic                       out_valid_q, out_valid_d;

  // Held request and datapath
  logic                       is_wr_q, is_wr_d;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic [ValueW-1:0]          val_q, val_d;
  logic [IdxW-1:0]            quo_q, quo_d;
  logic [BlockSizeW-1:0]      rem_q, rem_d;
  logic [WideW-1:0]           base_q, base_d;
  logic [KindW-1:0]           kind_q, kind_d;
  logic [ADDRESS_BITS-1:0]    addr_q, addr_d;
  logic [ValueW-1:0]          data_q, data_d;
  logic                       last_q, last_d;

  // Word store
  logic [ValueW-1:0]          mem_q [MemDepth];
  logic [ValueW-1:0]          rdata_q;
  logic                       mem_we, mem_re;
  logic [MemAw-1:0]           mem_waddr, mem_raddr;
  logic [ValueW-1:0]          mem_wdata;

  logic [BlockSizeW-1:0]      bs_eff;
  logic                       accept;
  logic [BlockSizeW:0]        div_t, div_sub;
  logic                       div_ge;
  logic                       cur_s;
  logic                       hit;
  logic [BlockSizeW-1:0]      fill_next;
  logic [WideW-1:0]           wb_addr, fill_addr;

  function automatic logic [MemAw-1:0] slot_addr(input logic s,
                                                  input logic [BlockSizeW-1:0] off);
    logic [BlockSizeW:0] a;
    a = s ? ((BlockSizeW+1)'(MAX_BLOCK_WORDS) + {1'b0, off}) : {1'b0, off};
    return a[MemAw-1:0];
  endfunction

  // Clamp the block size into 1..MAX_BLOCK_WORDS
  always_comb begin
    bs_eff = block_size_q;
    if (block_size_q == '0) begin
      bs_eff = BlockSizeW'(1);
    end else if (block_size_q > MaxBs) begin
      bs_eff = MaxBs;
    end
  end

  assign accept  = start && (state_q == S_IDLE);
  assign busy    = (state_q != S_IDLE);

  // One restoring-division step per cycle, quotient shifts in from the right
  assign div_t   = {rem_q, quo_q[IdxW-1]};
  assign div_ge  = (div_t >= {1'b0, bs_eff});
  assign div_sub = div_t - {1'b0, bs_eff};

  // quo_q[0] is the slot of the held request, rem_q its offset in the block
  assign cur_s     = quo_q[0];
  assign hit       = slot_valid_q[cur_s] && (slot_bn_q[cur_s] == quo_q);
  assign fill_next = fill_cnt_q + BlockSizeW'(1);
  assign wb_addr   = base_q + WideW'(wb_k_q);
  assign fill_addr = WideW'(idx_q - IdxW'(rem_q));

  always_comb begin
    state_d      = state_q;
    array_size_d = array_size_q;
    block_size_d = block_size_q;
    slot_valid_d = slot_valid_q;
    slot_dirty_d = slot_dirty_q;
    slot_bn_d    = slot_bn_q;
    waiting_d    = waiting_q;
    fill_cnt_d   = fill_cnt_q;
    div_cnt_d    = div_cnt_q;
    wb_k_d       = wb_k_q;
    out_valid_d  = 1'b0;
    is_wr_d      = is_wr_q;
    idx_d        = idx_q;
    val_d        = val_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    base_d       = base_q;
    kind_d       = kind_q;
    addr_d       = addr_q;
    data_d       = data_q;
    last_d       = last_q;
    mem_we       = 1'b0;
    mem_waddr    = slot_addr(cur_s, fill_cnt_q);
    mem_wdata    = value_i;
    mem_re       = 1'b0;
    mem_raddr    = slot_addr(cur_s, rem_q);

    // Drop register writes while a fill is outstanding
    if (cfg_we_i && !waiting_q) begin
      case (cfg_idx_i)
        CfgArraySize: array_size_d = cfg_data_i[ArraySizeW-1:0];
        CfgBlockSize: block_size_d = cfg_data_i[BlockSizeW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action_i)
            ActFill: begin
              if (!waiting_q) begin
                out_valid_d = 1'b1;
                kind_d      = KindProto;
                addr_d      = '0;
                data_d      = '0;
                last_d      = 1'b1;
              end else begin
                mem_we = (fill_cnt_q < MaxBs);
                if (fill_next >= bs_eff) begin
                  waiting_d           = 1'b0;
                  fill_cnt_d          = '0;
                  slot_valid_d[cur_s] = 1'b1;
                  slot_dirty_d[cur_s] = 1'b0;
                  state_d             = S_RD;
                end else begin
                  fill_cnt_d = fill_next;
                end
              end
            end
            ActRead, ActWrite: begin
              if (waiting_q) begin
                out_valid_d = 1'b1;
                kind_d      = KindProto;
                addr_d      = '0;
                data_d      = '0;
                last_d      = 1'b1;
              end else if (index_i[IndexW-1] ||
                           ($unsigned(index_i) >= array_size_q)) begin
                out_valid_d = 1'b1;
                kind_d      = KindRange;
                addr_d      = '0;
                data_d      = '0;
                last_d      = 1'b1;
              end else begin
                is_wr_d   = (action_i == ActWrite);
                idx_d     = index_i[IdxW-1:0];
                val_d     = value_i;
                quo_d     = index_i[IdxW-1:0];
                rem_d     = '0;
                div_cnt_d = '0;
                state_d   = S_DIV;
              end
            end
            default: begin
              out_valid_d = 1'b1;
              kind_d      = KindProto;
              addr_d      = '0;
              data_d      = '0;
              last_d      = 1'b1;
            end
          endcase
        end
      end
      S_DIV: begin
        quo_d     = {quo_q[IdxW-2:0], div_ge};
        rem_d     = div_ge ? div_sub[BlockSizeW-1:0] : div_t[BlockSizeW-1:0];
        div_cnt_d = div_cnt_q + CntW'(1);
        if (div_cnt_q == CntW'(IdxW - 1)) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (hit) begin
          state_d = S_RD;
        end else if (slot_valid_q[cur_s] && slot_dirty_q[cur_s]) begin
          base_d  = WideW'(slot_bn_q[cur_s]) * WideW'(bs_eff);
          wb_k_d  = '0;
          state_d = S_WB_RD;
        end else begin
          state_d = S_FILL_REQ;
        end
      end
      S_WB_RD: begin
        mem_re    = 1'b1;
        mem_raddr = slot_addr(cur_s, wb_k_q);
        state_d   = S_WB_OUT;
      end
      S_WB_OUT: begin
        out_valid_d = 1'b1;
        kind_d      = KindWb;
        addr_d      = wb_addr[ADDRESS_BITS-1:0];
        data_d      = rdata_q;
        last_d      = 1'b0;
        wb_k_d      = wb_k_q + BlockSizeW'(1);
        state_d     = (wb_k_d >= bs_eff) ? S_FILL_REQ : S_WB_RD;
      end
      S_FILL_REQ: begin
        out_valid_d         = 1'b1;
        kind_d              = KindFill;
        addr_d              = fill_addr[ADDRESS_BITS-1:0];
        data_d              = '0;
        last_d              = 1'b1;
        slot_valid_d[cur_s] = 1'b0;
        slot_dirty_d[cur_s] = 1'b0;
        slot_bn_d[cur_s]    = quo_q;
        waiting_d           = 1'b1;
        fill_cnt_d          = '0;
        state_d             = S_IDLE;
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_HIT_RD;
      end
      S_HIT_RD: begin
        out_valid_d = 1'b1;
        addr_d      = '0;
        last_d      = 1'b1;
        if (is_wr_q) begin
          kind_d = KindWrite;
          data_d = '0;
          // Mark dirty only on a real change of the stored word
          if (rdata_q != val_q) begin
            mem_we              = 1'b1;
            mem_waddr           = slot_addr(cur_s, rem_q);
            mem_wdata           = val_q;
            slot_dirty_d[cur_s] = 1'b1;
          end
        end else begin
          kind_d = KindRead;
          data_d = rdata_q;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      array_size_q <= ArraySizeRst;
      block_size_q <= BlockSizeRst;
      slot_valid_q <= '0;
      slot_dirty_q <= '0;
      slot_bn_q    <= '0;
      waiting_q    <= 1'b0;
      fill_cnt_q   <= '0;
      div_cnt_q    <= '0;
      wb_k_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      array_size_q <= array_size_d;
      block_size_q <= block_size_d;
      slot_valid_q <= slot_valid_d;
      slot_dirty_q <= slot_dirty_d;
      slot_bn_q    <= slot_bn_d;
      waiting_q    <= waiting_d;
      fill_cnt_q   <= fill_cnt_d;
      div_cnt_q    <= div_cnt_d;
      wb_k_q       <= wb_k_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_wr_q <= is_wr_d;
    idx_q   <= idx_d;
    val_q   <= val_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    base_q  <= base_d;
    kind_q  <= kind_d;
    addr_q  <= addr_d;
    data_q  <= data_d;
    last_q  <= last_d;
  end

  // Word store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign result_valid_o = out_valid_q;
  assign kind_o         = kind_q;
  assign address_o      = addr_q;
  assign data_o         = data_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  // A pending fill only ever waits in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    waiting_q |-> (state_q == S_IDLE))
    else $error("fill awaited outside idle");

  // Fill counter never reaches the block size while a fill is awaited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    waiting_q |-> (fill_cnt_q < bs_eff))
    else $error("fill counter overran block size");

  // Issuing the fill request arms the fill wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL_REQ) |=> (waiting_q && result_valid_o && last_o))
    else $error("fill request did not arm fill wait");

  // Every completed access produces a final result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HIT_RD) |=> (result_valid_o && last_o && !waiting_q))
    else $error("access completion lost its result");
`endif

endmodule

// ===== tb/two_slot_writeback_block_cache_unit_tb.sv =====
// Self-checking testbench for the two-slot write-back block cache unit.
`timescale 1ns / 100ps

module two_slot_writeback_block_cache_unit_tb;
  import tswbc_pkg::*;

  localparam int unsigned MAX_WORDS = MaxBlockWordsDef;
  localparam int unsigned ADDR_W = AddressBitsDef;
  // Settle time before a register write or the final verdict: covers the
  // divider, a lookup and the fill completion with room to spare.
  localparam int unsigned SETTLE_CYCLES = 40;
  // Worst case is far below this limit.
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct {
    kind_e kind;
    logic [ADDR_W-1:0] addr;
    logic [ValueW-1:0] data;
    logic last;
  } cache_answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [ActionW-1:0] action_i = ActRead;
  logic signed [IndexW-1:0] index_i = '0;
  logic [ValueW-1:0] value_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgArraySize;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic result_valid_o;
  logic [KindW-1:0] kind_o;
  logic [ADDR_W-1:0] address_o;
  logic [ValueW-1:0] data_o;
  logic last_o;

  // Answers the cache owes us, oldest first.
  cache_answer_t cache_answers[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Mirror of the cache: registers, word store, slot tags and the fill in flight.
  logic [ArraySizeW-1:0] reg_array_size;
  logic [BlockSizeW-1:0] reg_block_size;
  logic [ValueW-1:0] m_store[2*MAX_WORDS];
  logic [BlockNumW-1:0] m_tag[2];
  bit m_valid[2];
  bit m_dirty[2];
  bit fill_wait;
  int unsigned fill_words_in;
  bit held_is_write;
  logic [IdxW-1:0] held_index;
  logic [ValueW-1:0] held_value;

  two_slot_writeback_block_cache_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .index_i       (index_i),
    .value_i       (value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .kind_o        (kind_o),
    .address_o     (address_o),
    .data_o        (data_o),
    .last_o        (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d answers outstanding", $time, cycle_count,
               cache_answers.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Cache mirror
  // ---------------------------------------------------------------------------

  // Block size as the hardware applies it: zero acts as one, oversize clamps.
  function automatic int unsigned used_block_size();
    if (reg_block_size == 0) return 1;
    if (reg_block_size > MAX_WORDS) return MAX_WORDS;
    return reg_block_size;
  endfunction

  // Word a hit on this index would touch under the current block size.
  function automatic logic [ValueW-1:0] stored_word(input logic [IdxW-1:0] idx);
    int unsigned bs;
    bs = used_block_size();
    return m_store[(((idx / bs) & 1) * MAX_WORDS) + (idx % bs)];
  endfunction

  function automatic void owe_answer(input kind_e kind, input int unsigned addr,
                                     input logic [ValueW-1:0] data, input logic last);
    cache_answer_t a;
    a.kind = kind;
    a.addr = addr[ADDR_W-1:0];
    a.data = data;
    a.last = last;
    cache_answers.push_back(a);
  endfunction

  // Finish a read or write on a slot that holds its block.
  function automatic void finish_access(input logic [IdxW-1:0] idx, input bit is_write,
                                        input logic [ValueW-1:0] val);
    int unsigned bs, s, pos;
    bs = used_block_size();
    s = (idx / bs) & 1;
    pos = s * MAX_WORDS + (idx % bs);
    if (is_write) begin
      // Only a bitwise change marks the slot dirty.
      if (m_store[pos] !== val) begin
        m_store[pos] = val;
        m_dirty[s] = 1'b1;
      end
      owe_answer(KindWrite, 0, '0, 1'b1);
    end else begin
      owe_answer(KindRead, 0, m_store[pos], 1'b1);
    end
  endfunction

  function automatic void apply_register_write(input logic [CfgIdxW-1:0] which,
                                               input logic [CfgDataW-1:0] value);
    // The cache locks its registers while a fill is outstanding.
    if (fill_wait) return;
    if (which == CfgArraySize) reg_array_size = value;
    else reg_block_size = value[BlockSizeW-1:0];
  endfunction

  function automatic void predict_cache_request(input action_e act,
                                                input logic [IndexW-1:0] raw,
                                                input logic [ValueW-1:0] val);
    int unsigned bs, blk, s, base, k;
    logic [IdxW-1:0] idx;
    bs = used_block_size();
    if (act == ActFill) begin
      if (!fill_wait) begin
        owe_answer(KindProto, 0, '0, 1'b1);
        return;
      end
      s = (held_index / bs) & 1;
      if (fill_words_in < MAX_WORDS) m_store[s * MAX_WORDS + fill_words_in] = val;
      fill_words_in = (fill_words_in + 1) & 63;
      // Fill words before the last one answer nothing.
      if (fill_words_in < bs) return;
      fill_wait = 1'b0;
      fill_words_in = 0;
      m_valid[s] = 1'b1;
      m_dirty[s] = 1'b0;
      finish_access(held_index, held_is_write, held_value);
      return;
    end
    if (act == ActBad || fill_wait) begin
      owe_answer(KindProto, 0, '0, 1'b1);
      return;
    end
    if (raw[IndexW-1] || raw >= reg_array_size) begin
      owe_answer(KindRange, 0, '0, 1'b1);
      return;
    end
    idx = raw[IdxW-1:0];
    blk = idx / bs;
    s = blk & 1;
    if (m_valid[s] && m_tag[s] == blk[BlockNumW-1:0]) begin
      finish_access(idx, act == ActWrite, val);
      return;
    end
    // Miss: flush a dirty victim over the whole block, then ask for the new one.
    if (m_valid[s] && m_dirty[s]) begin
      base = m_tag[s] * bs;
      for (k = 0; k < bs; k++) owe_answer(KindWb, base + k, m_store[s * MAX_WORDS + k], 1'b0);
    end
    owe_answer(KindFill, blk * bs, '0, 1'b1);
    m_valid[s] = 1'b0;
    m_dirty[s] = 1'b0;
    m_tag[s] = blk[BlockNumW-1:0];
    fill_wait = 1'b1;
    fill_words_in = 0;
    held_is_write = (act == ActWrite);
    held_index = idx;
    held_value = val;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: sample mid-cycle, since each result holds for exactly one cycle.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : check_answers
    cache_answer_t want;
    if (rst_ni === 1'b1 && result_valid_o !== 1'b0) begin
      if (cache_answers.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind %0d addr %h data %h last %b",
                 $time, kind_o, address_o, data_o, last_o);
        mismatch_count++;
      end else begin
        want = cache_answers.pop_front();
        if (kind_o !== want.kind) begin
          $display("%0t: kind mismatch: expected %0d, got %0d", $time, want.kind, kind_o);
          mismatch_count++;
        end
        if (address_o !== want.addr) begin
          $display("%0t: address mismatch: expected %h, got %h", $time, want.addr, address_o);
          mismatch_count++;
        end
        if (data_o !== want.data) begin
          $display("%0t: data mismatch: expected %h, got %h", $time, want.data, data_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last mismatch: expected %b, got %b", $time, want.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driving. Every task starts and ends on a rising-edge time step.
  // ---------------------------------------------------------------------------

  // Present one request and hold it until the cache takes it. Leave start high
  // so a following request goes back to back.
  task automatic issue_request(input action_e act, input logic [IndexW-1:0] idx,
                               input logic [ValueW-1:0] val);
    start <= 1'b1;
    action_i <= act;
    index_i <= idx;
    value_i <= val;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_cache_request(act, idx, val);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold off until every owed answer has arrived.
  task automatic wait_for_answers();
    start <= 1'b0;
    do @(posedge clk_i); while (cache_answers.size() != 0);
  endtask

  // Register writes go in only once the cache has gone quiet.
  task automatic write_register(input logic [CfgIdxW-1:0] which,
                                input logic [CfgDataW-1:0] value);
    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= which;
    cfg_data_i <= value;
    @(posedge clk_i);
    apply_register_write(which, value);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stream random fill words until the outstanding block is complete.
  task automatic supply_fill_words();
    while (fill_wait) issue_request(ActFill, IndexW'($urandom), {$urandom, $urandom});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Load both slots at full block size so every word of the store holds known data.
  task automatic test_fill_both_slots();
    issue_request(ActRead, 21'd0, 64'd0);
    supply_fill_words();
    issue_request(ActRead, 21'd32, 64'd0);
    supply_fill_words();
    issue_request(ActRead, 21'd63, 64'd0);
  endtask

  task automatic test_hits_and_clean_miss();
    write_register(CfgBlockSize, 21'd2);
    issue_request(ActRead, 21'd1, 64'd0);
    // Rewrite the stored word unchanged: the slot must stay clean.
    issue_request(ActWrite, 21'd1, stored_word(20'd1));
    issue_request(ActRead, 21'd4, 64'd0);
    supply_fill_words();
    issue_request(ActWrite, 21'd5, 64'hFFFF_FFFF_FFFF_FFFF);
    issue_request(ActWrite, 21'd4, 64'd0);
  endtask

  task automatic test_dirty_eviction();
    // Block 0 displaces the dirty block 2 in slot 0.
    issue_request(ActRead, 21'd0, 64'd0);
    supply_fill_words();
    issue_request(ActRead, 21'd2, 64'd0);
  endtask

  task automatic test_errors_and_range();
    issue_request(ActBad, 21'd0, 64'd0);
    issue_request(ActFill, 21'd0, 64'd0);
    issue_request(ActRead, 21'h1FFFFF, 64'd0);
    issue_request(ActWrite, 21'h100000, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(CfgArraySize, 21'd8);
    issue_request(ActRead, 21'd8, 64'd0);
    issue_request(ActRead, 21'd7, 64'd0);
    supply_fill_words();
    write_register(CfgArraySize, 21'd0);
    issue_request(ActRead, 21'd0, 64'd0);
  endtask

  task automatic test_fill_wait_rules();
    write_register(CfgArraySize, 21'h1FFFFF);
    issue_request(ActRead, 21'h0FFFFF, 64'd0);
    // The cache is parked on the fill: this register write must not land.
    wait_for_answers();
    write_register(CfgArraySize, 21'd0);
    issue_request(ActRead, 21'd0, 64'd0);
    issue_request(ActWrite, 21'd3, 64'd1);
    issue_request(ActBad, 21'd0, 64'd0);
    supply_fill_words();
    issue_request(ActRead, 21'd0, 64'd0);
    issue_request(ActWrite, 21'h0FFFFF, ~stored_word(20'hFFFFF));
  endtask

  // Tags stored under one block size are reused under another; the victim's
  // writeback base then overflows the address width and must wrap.
  task automatic test_address_wrap();
    write_register(CfgBlockSize, 21'd0);
    issue_request(ActRead, 21'h0FFFFF, 64'd0);
    supply_fill_words();
    issue_request(ActWrite, 21'h0FFFFF, ~stored_word(20'hFFFFF));
    write_register(CfgBlockSize, 21'd2);
    issue_request(ActRead, 21'd2, 64'd0);
    supply_fill_words();
  endtask

  // Mostly well-formed traffic: accesses clustered on a few blocks at both ends
  // of the array, with complete fills after misses, plus a share of noise.
  task automatic test_random_traffic(input logic [CfgDataW-1:0] bs_setting,
                                     input logic [CfgDataW-1:0] size_setting,
                                     input int unsigned item_count, input bit with_gaps);
    int unsigned sent, roll, bs, limit, off;
    logic [IndexW-1:0] idx;
    logic [ValueW-1:0] val;
    write_register(CfgBlockSize, bs_setting);
    write_register(CfgArraySize, size_setting);
    bs = used_block_size();
    limit = (reg_array_size > 21'h100000) ? 32'h100000 : reg_array_size;
    sent = 0;
    while (sent < item_count || fill_wait) begin
      roll = $urandom_range(0, 99);
      val = {$urandom, $urandom};
      if (fill_wait && roll < 90) begin
        issue_request(ActFill, IndexW'($urandom), val);
      end else if (fill_wait || roll < 5) begin
        // Noise: random requests during a fill or while none is awaited, such as a fill word nobody asked for.
        issue_request(action_e'($urandom_range(0, 3)), IndexW'($urandom), val);
      end else if (roll < 8) begin
        issue_request(ActBad, IndexW'($urandom), val);
      end else if (roll < 18 || limit == 0) begin
        if (reg_array_size < 21'h100000 && $urandom_range(0, 1) == 1)
          idx = IndexW'($urandom_range(reg_array_size, 20'hFFFFF));
        else
          idx = {1'b1, IdxW'($urandom)};
        issue_request(roll[0] ? ActWrite : ActRead, idx, val);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: idx = IndexW'($urandom_range(0, 6 * bs - 1) % limit);
          6, 7: begin
            off = $urandom_range(0, 4 * bs);
            idx = (off >= limit) ? '0 : IndexW'(limit - 1 - off);
          end
          default: idx = IndexW'($urandom % limit);
        endcase
        if ($urandom_range(0, 1) == 1) begin
          // Often rewrite the word already there, which must not dirty the slot.
          if ($urandom_range(0, 9) < 3) val = stored_word(idx[IdxW-1:0]);
          issue_request(ActWrite, idx, val);
        end else begin
          issue_request(ActRead, idx, val);
        end
      end
      sent++;
      if (with_gaps) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) wait_for_answers();
        else if (roll < 30) pause_sender($urandom_range(1, 8));
      end
    end
  endtask

  initial begin
    reg_array_size = ArraySizeRst;
    reg_block_size = BlockSizeRst;
    foreach (m_store[i]) m_store[i] = '0;
    m_tag[0] = '0;
    m_tag[1] = '0;
    m_valid[0] = 1'b0;
    m_valid[1] = 1'b0;
    m_dirty[0] = 1'b0;
    m_dirty[1] = 1'b0;
    fill_wait = 1'b0;
    fill_words_in = 0;
    held_is_write = 1'b0;
    held_index = '0;
    held_value = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_both_slots();
    test_hits_and_clean_miss();
    test_dirty_eviction();
    test_errors_and_range();
    test_fill_wait_rules();
    test_address_wrap();
    test_random_traffic(21'd4, 21'h100000, 10, 1'b1);
    test_random_traffic(21'd1, 21'd200, 8, 1'b1);
    test_random_traffic(21'd63, 21'h1FFFFF, 6, 1'b1);
    test_random_traffic(21'd3, 21'h0FFFFF, 10, 1'b0);

    // Drain, then give stray results time to show up.
    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
